@@ sv/lcdns_pkg.sv @@
// Shared types, opcodes and the power-up action table for the character LCD
// nibble sequencer. No dependencies; the design scopes it, the bench imports it.
package lcdns_pkg;

	localparam int ROW_COUNT   = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int STEP_W      = 4;

	localparam logic [2:0] OP_INIT      = 3'd0;
	localparam logic [2:0] OP_COMMAND   = 3'd1;
	localparam logic [2:0] OP_DATA      = 3'd2;
	localparam logic [2:0] OP_SET_CUR   = 3'd3;
	localparam logic [2:0] OP_CUR_LEFT  = 3'd4;
	localparam logic [2:0] OP_CUR_RIGHT = 3'd5;
	localparam logic [2:0] OP_BLINK_ON  = 3'd6;
	localparam logic [2:0] OP_BLINK_OFF = 3'd7;

	localparam logic [1:0] CFG_ROW_ONE   = 2'd0;
	localparam logic [1:0] CFG_ROW_TWO   = 2'd1;
	localparam logic [1:0] CFG_ROW_THREE = 2'd2;

	localparam logic [6:0] ROW_ONE_RST   = 7'd64;
	localparam logic [6:0] ROW_TWO_RST   = 7'd20;
	localparam logic [6:0] ROW_THREE_RST = 7'd84;

	localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
	localparam logic [7:0] CMD_SHIFT_LEFT = 8'h10;
	localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h14;
	localparam logic [7:0] CMD_DISP_CTRL  = 8'h08;
	localparam logic [3:0] DISP_BLINK_ON  = 4'hF;
	localparam logic [3:0] DISP_BLINK_OFF = 4'h0;

	localparam logic [13:0] WAIT_NIBBLE = 14'd100;
	localparam logic [13:0] WAIT_CMD    = 14'd140;

	localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(10);

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] byte_value;
		logic [6:0] column;
		logic [1:0] row;
	} req_t;

	typedef struct packed {
		logic        select_level;
		logic [3:0]  nibble;
		logic        pulse;
		logic [13:0] wait_us;
		logic        last;
		logic [6:0]  cursor_col;
		logic [1:0]  cursor_row;
	} rsp_t;

	// One classified request as it waits in the queue
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] byte_value;
		logic       tail_long;
		logic [6:0] cursor_col;
		logic [1:0] cursor_row;
	} job_t;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nibble;
		logic        pulse;
		logic [13:0] wait_us;
	} action_t;

	// Power-up sequence: settle wait, 3,3,3,2, then 0x28, 0x0C, 0x01 with clear tail
	function automatic action_t init_action(input logic [STEP_W-1:0] step);
		action_t a;
		a.rs    = 1'b0;
		a.pulse = 1'b1;
		unique case (step)
			4'd0: begin a.nibble = 4'h0; a.pulse = 1'b0; a.wait_us = 14'd15000; end
			4'd1: begin a.nibble = 4'h3; a.wait_us = 14'd5100; end
			4'd2: begin a.nibble = 4'h3; a.wait_us = 14'd200; end
			4'd3: begin a.nibble = 4'h3; a.wait_us = 14'd140; end
			4'd4: begin a.nibble = 4'h2; a.wait_us = 14'd100; end
			4'd5: begin a.nibble = 4'h2; a.wait_us = 14'd100; end
			4'd6: begin a.nibble = 4'h8; a.wait_us = 14'd140; end
			4'd7: begin a.nibble = 4'h0; a.wait_us = 14'd100; end
			4'd8: begin a.nibble = 4'hC; a.wait_us = 14'd140; end
			4'd9: begin a.nibble = 4'h0; a.wait_us = 14'd100; end
			4'd10: begin a.nibble = 4'h1; a.wait_us = 14'd2140; end
			default: begin a.nibble = 4'h0; a.pulse = 1'b0; a.wait_us = 14'd0; end
		endcase
		return a;
	endfunction

endpackage

@@ sv/lcdns_front.sv @@
// Front end: takes requests and configuration writes, tracks cursor and display
// bits, and turns each request into one queued job. Uses lcdns_pkg.
module lcdns_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	input  logic                req_valid,
	output logic                req_ready,
	input  lcdns_pkg::req_t     req,
	input  logic                queue_full,
	output logic                push,
	output lcdns_pkg::job_t     push_job
);

	logic [6:0] row_one_q, row_two_q, row_three_q;
	logic [6:0] col_q;
	logic [1:0] row_q;
	logic [3:0] disp_q;

	logic [6:0] col_n;
	logic [1:0] row_n;
	logic [3:0] disp_n;
	logic [1:0] row_sat;
	logic [6:0] row_off;
	logic [6:0] addr;

	assign cfg_ready = 1'b1;
	assign req_ready = !queue_full;
	assign push      = req_valid && req_ready;

	always_comb begin
		if ({1'b0, req.row} >= 3'(lcdns_pkg::ROW_COUNT))
			row_sat = 2'(lcdns_pkg::ROW_COUNT - 1);
		else
			row_sat = req.row;
	end

	always_comb begin
		unique case (row_sat)
			2'd0: row_off = 7'd0;
			2'd1: row_off = row_one_q;
			2'd2: row_off = row_two_q;
			default: row_off = row_three_q;
		endcase
	end

	assign addr = req.column + row_off;

	always_comb begin
		col_n  = col_q;
		row_n  = row_q;
		disp_n = disp_q;
		push_job.is_init    = 1'b0;
		push_job.rs         = 1'b0;
		push_job.byte_value = req.byte_value;
		push_job.tail_long  = 1'b1;
		unique case (req.opcode)
			lcdns_pkg::OP_INIT: begin
				push_job.is_init    = 1'b1;
				push_job.byte_value = 8'h00;
				push_job.tail_long  = 1'b0;
			end
			lcdns_pkg::OP_COMMAND: begin
			end
			lcdns_pkg::OP_DATA: begin
				push_job.rs        = 1'b1;
				push_job.tail_long = 1'b0;
				col_n              = col_q + 7'd1;
			end
			lcdns_pkg::OP_SET_CUR: begin
				col_n               = req.column;
				row_n               = row_sat;
				push_job.byte_value = lcdns_pkg::CMD_SET_DDRAM | {1'b0, addr};
			end
			lcdns_pkg::OP_CUR_LEFT: begin
				col_n               = col_q - 7'd1;
				push_job.byte_value = lcdns_pkg::CMD_SHIFT_LEFT;
			end
			lcdns_pkg::OP_CUR_RIGHT: begin
				col_n               = col_q + 7'd1;
				push_job.byte_value = lcdns_pkg::CMD_SHIFT_RIGHT;
			end
			lcdns_pkg::OP_BLINK_ON: begin
				disp_n              = lcdns_pkg::DISP_BLINK_ON;
				push_job.byte_value = lcdns_pkg::CMD_DISP_CTRL | {4'h0, disp_n};
			end
			default: begin
				disp_n              = lcdns_pkg::DISP_BLINK_OFF;
				push_job.byte_value = lcdns_pkg::CMD_DISP_CTRL | {4'h0, disp_n};
			end
		endcase
		push_job.cursor_col = col_n;
		push_job.cursor_row = row_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= 7'd0;
			row_q  <= 2'd0;
			disp_q <= 4'd0;
		end else if (push) begin
			col_q  <= col_n;
			row_q  <= row_n;
			disp_q <= disp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_one_q   <= lcdns_pkg::ROW_ONE_RST;
			row_two_q   <= lcdns_pkg::ROW_TWO_RST;
			row_three_q <= lcdns_pkg::ROW_THREE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lcdns_pkg::CFG_ROW_ONE:   row_one_q   <= cfg_data;
				lcdns_pkg::CFG_ROW_TWO:   row_two_q   <= cfg_data;
				lcdns_pkg::CFG_ROW_THREE: row_three_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ sv/lcdns_queue.sv @@
// Short job queue between the front and back ends of the LCD sequencer.
// Register array with count; depth and widths come from lcdns_pkg.
module lcdns_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lcdns_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output lcdns_pkg::job_t head
);

	lcdns_pkg::job_t                 mem_q [lcdns_pkg::QUEUE_DEPTH];
	logic [lcdns_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [lcdns_pkg::QCNT_W-1:0]    count_q;

	assign full       = (count_q == lcdns_pkg::QCNT_W'(lcdns_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ sv/lcdns_back.sv @@
// Back end: steps through the head job one pin action per cycle and holds each
// action in the output register, stalling until it is taken. Uses lcdns_pkg.
module lcdns_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  lcdns_pkg::job_t head,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output lcdns_pkg::rsp_t rsp
);

	logic [lcdns_pkg::STEP_W-1:0] step_q;
	logic                         rsp_valid_q;
	lcdns_pkg::rsp_t              rsp_q;

	lcdns_pkg::action_t act;
	logic               step_last;
	logic               load;

	always_comb begin
		if (head.is_init) begin
			act       = lcdns_pkg::init_action(step_q);
			step_last = (step_q == lcdns_pkg::INIT_LAST);
		end else begin
			act.rs    = head.rs;
			act.pulse = 1'b1;
			if (step_q == '0) begin
				act.nibble  = head.byte_value[7:4];
				act.wait_us = lcdns_pkg::WAIT_NIBBLE;
			end else begin
				act.nibble  = head.byte_value[3:0];
				act.wait_us = head.tail_long ? lcdns_pkg::WAIT_CMD : lcdns_pkg::WAIT_NIBBLE;
			end
			step_last = (step_q != '0);
		end
	end

	assign load      = head_valid && (!rsp_valid_q || rsp_ready);
	assign pop       = load && step_last;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
				step_q      <= step_last ? '0 : step_q + 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.select_level <= act.rs;
			rsp_q.nibble       <= act.nibble;
			rsp_q.pulse        <= act.pulse;
			rsp_q.wait_us      <= act.wait_us;
			rsp_q.last         <= step_last;
			rsp_q.cursor_col   <= head.cursor_col;
			rsp_q.cursor_row   <= head.cursor_row;
		end
	end

`ifndef NO_ASSERTIONS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= lcdns_pkg::INIT_LAST)
		else $error("action step beyond power-up sequence");
	a_step_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0 |-> head_valid)
		else $error("job left the queue mid-sequence");
	a_byte_two_steps: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !head.is_init |-> step_q <= 1)
		else $error("byte job past its second nibble");
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rsp_valid && rsp.last)
		else $error("popped job without a last action");
`endif

endmodule

@@ sv/char_lcd_nibble_sequencer_core.sv @@
// Top level of the character LCD 4-bit sequencer: front end, job queue, back end.
// Depends on lcdns_pkg, lcdns_front, lcdns_queue and lcdns_back.
//
// Each request becomes a list of pin actions (RS level, nibble, enable pulse,
// wait in microseconds), delivered one per cycle on the rsp channel unless
// stalled by rsp_ready, with last set on the final one: a command, data, cursor
// or blink request gives two actions, init gives eleven. Requests are accepted
// one per cycle while the four-entry job queue has room, so the output stage,
// one action per cycle unless stalled, sets the sustained rate. The user must
// write row offsets (cfg channel, index 0..2) only while idle; nothing checks it.
module char_lcd_nibble_sequencer_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [6:0]      cfg_data,
	input  logic            req_valid,
	output logic            req_ready,
	input  lcdns_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output lcdns_pkg::rsp_t rsp
);

	logic            push;
	lcdns_pkg::job_t push_job;
	logic            queue_full;
	logic            pop;
	logic            head_valid;
	lcdns_pkg::job_t head;

	lcdns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	lcdns_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lcdns_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

@@ bench/char_lcd_nibble_sequencer_core_checker.sv @@
`timescale 1ns / 1ps
// Checker for the character LCD nibble sequencer: watches the cfg, req and rsp
// channels, predicts each request's pin actions and compares them field by field.
// Depends on lcdns_pkg for the payload structs, opcodes and register indexes.
module char_lcd_nibble_sequencer_core_checker
	import lcdns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       req_valid,
	input  logic       req_ready,
	input  req_t       req,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  rsp_t       rsp,
	output int         errors,
	output int         pending
);

	localparam logic [7:0]  SET_ADDR_BIT  = 8'h80;
	localparam logic [7:0]  SHIFT_LEFT    = 8'h10;
	localparam logic [7:0]  SHIFT_RIGHT   = 8'h14;
	localparam logic [7:0]  DISPLAY_CTRL  = 8'h08;
	localparam logic [13:0] HOLD_NIBBLE   = 14'd100;
	localparam logic [13:0] HOLD_COMMAND  = 14'd140;
	localparam logic [13:0] HOLD_CLEAR    = 14'd2140;

	logic [6:0] row_base [0:3];
	logic [6:0] col_now;
	logic [1:0] row_now;
	logic [3:0] disp_bits;
	rsp_t       actions_due [$];
	rsp_t       want;

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic add_action(input logic rs, input logic [3:0] nib, input logic pul,
			input logic [13:0] hold, input logic fin);
		rsp_t a;
		a.select_level = rs;
		a.nibble       = nib;
		a.pulse        = pul;
		a.wait_us      = hold;
		a.last         = fin;
		a.cursor_col   = col_now;
		a.cursor_row   = row_now;
		actions_due.push_back(a);
	endtask

	task automatic add_byte(input logic rs, input logic [7:0] b, input logic [13:0] tail,
			input logic fin);
		add_action(rs, b[7:4], 1'b1, HOLD_NIBBLE, 1'b0);
		add_action(rs, b[3:0], 1'b1, tail, fin);
	endtask

	// Update the tracked state first: every action carries the cursor after the request
	task automatic sequence_request(input req_t r);
		logic [1:0] row_sel;
		logic [6:0] addr;
		case (r.opcode)
			OP_INIT: begin
				add_action(1'b0, 4'h0, 1'b0, 14'd15000, 1'b0);
				add_action(1'b0, 4'h3, 1'b1, 14'd5100, 1'b0);
				add_action(1'b0, 4'h3, 1'b1, 14'd200, 1'b0);
				add_action(1'b0, 4'h3, 1'b1, 14'd140, 1'b0);
				add_action(1'b0, 4'h2, 1'b1, 14'd100, 1'b0);
				add_byte(1'b0, 8'h28, HOLD_COMMAND, 1'b0);
				add_byte(1'b0, 8'h0C, HOLD_COMMAND, 1'b0);
				add_byte(1'b0, 8'h01, HOLD_CLEAR, 1'b1);
			end
			OP_COMMAND: add_byte(1'b0, r.byte_value, HOLD_COMMAND, 1'b1);
			OP_DATA: begin
				col_now = col_now + 7'd1;
				add_byte(1'b1, r.byte_value, HOLD_NIBBLE, 1'b1);
			end
			OP_SET_CUR: begin
				row_sel = r.row;
				if (int'(row_sel) >= ROW_COUNT)
					row_sel = 2'(ROW_COUNT - 1);
				addr    = r.column + row_base[row_sel];
				col_now = r.column;
				row_now = row_sel;
				add_byte(1'b0, SET_ADDR_BIT | {1'b0, addr}, HOLD_COMMAND, 1'b1);
			end
			OP_CUR_LEFT: begin
				col_now = col_now - 7'd1;
				add_byte(1'b0, SHIFT_LEFT, HOLD_COMMAND, 1'b1);
			end
			OP_CUR_RIGHT: begin
				col_now = col_now + 7'd1;
				add_byte(1'b0, SHIFT_RIGHT, HOLD_COMMAND, 1'b1);
			end
			OP_BLINK_ON: begin
				disp_bits = 4'hF;
				add_byte(1'b0, DISPLAY_CTRL | {4'h0, disp_bits}, HOLD_COMMAND, 1'b1);
			end
			default: begin
				disp_bits = 4'h0;
				add_byte(1'b0, DISPLAY_CTRL | {4'h0, disp_bits}, HOLD_COMMAND, 1'b1);
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [13:0] exp_v,
			input logic [13:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base[0] = 7'd0;
			row_base[1] = 7'd64;
			row_base[2] = 7'd20;
			row_base[3] = 7'd84;
			col_now     = 7'd0;
			row_now     = 2'd0;
			disp_bits   = 4'h0;
			actions_due.delete();
			pending     = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROW_ONE:   row_base[1] = cfg_data;
					CFG_ROW_TWO:   row_base[2] = cfg_data;
					CFG_ROW_THREE: row_base[3] = cfg_data;
					default: ;
				endcase
			end
			// Retire the output beat before predicting a request taken at the same edge
			if (rsp_valid && rsp_ready) begin
				if (actions_due.size() == 0) begin
					$error("action beat with none expected: nibble %0h wait %0d",
						rsp.nibble, rsp.wait_us);
					errors++;
				end else begin
					want = actions_due.pop_front();
					check_field("select_level", want.select_level, rsp.select_level);
					check_field("nibble", want.nibble, rsp.nibble);
					check_field("pulse", want.pulse, rsp.pulse);
					check_field("wait_us", want.wait_us, rsp.wait_us);
					check_field("last", want.last, rsp.last);
					check_field("cursor_col", want.cursor_col, rsp.cursor_col);
					check_field("cursor_row", want.cursor_row, rsp.cursor_row);
				end
			end
			if (req_valid && req_ready)
				sequence_request(req);
			pending = actions_due.size();
		end
	end

endmodule

@@ bench/char_lcd_nibble_sequencer_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the LCD nibble sequencer bench: clock, reset, request and register
// stimulus, output stalls and the verdict. Depends on lcdns_pkg and the checker.
module char_lcd_nibble_sequencer_core_tb;
	import lcdns_pkg::*;

	localparam int         ITEMS_PER_PHASE = 73;
	localparam int         SETTLE_CYCLES   = 16;
	localparam int         WATCHDOG_LIMIT  = 2000;
	localparam logic [1:0] CFG_SPARE       = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	logic       req_valid;
	logic       req_ready;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;

	int errors;
	int pending;
	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;

	char_lcd_nibble_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	char_lcd_nibble_sequencer_core_checker action_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// End the run if no beat moves on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("char_lcd_nibble_sequencer_core_tb: done, errors");
				$finish;
			end
		end
	end

	function automatic req_t make_req(input logic [2:0] op, input logic [7:0] b,
			input logic [6:0] col, input logic [1:0] row);
		req_t r;
		r.opcode     = op;
		r.byte_value = b;
		r.column     = col;
		r.row        = row;
		return r;
	endfunction

	function automatic req_t random_req();
		logic [2:0] op;
		op = ($urandom_range(99) < 4) ? OP_INIT : 3'($urandom_range(1, 7));
		return make_req(op, 8'($urandom), 7'($urandom), 2'($urandom));
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat, valid left high
	task automatic push_req(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int phase;
		int n;
		int send_pcts [4];
		int stall_pcts [4];

		send_pcts  = '{0, 61, 0, 36};
		stall_pcts = '{0, 0, 61, 36};
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_ready     = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		quiet_cycles  = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every operation, byte extremes, row offsets at reset, column wrap
		push_req(make_req(OP_INIT, 8'h00, 7'd0, 2'd0));
		push_req(make_req(OP_COMMAND, 8'h00, 7'd0, 2'd0));
		push_req(make_req(OP_COMMAND, 8'hFF, 7'd127, 2'd3));
		push_req(make_req(OP_COMMAND, 8'hA5, 7'd0, 2'd0));
		push_req(make_req(OP_DATA, 8'h00, 7'd0, 2'd0));
		push_req(make_req(OP_DATA, 8'hFF, 7'd0, 2'd0));
		push_req(make_req(OP_DATA, 8'h5A, 7'd0, 2'd0));
		push_req(make_req(OP_SET_CUR, 8'hFF, 7'd0, 2'd0));
		push_req(make_req(OP_SET_CUR, 8'h00, 7'd127, 2'd1));
		push_req(make_req(OP_SET_CUR, 8'h00, 7'd64, 2'd2));
		push_req(make_req(OP_SET_CUR, 8'h00, 7'd127, 2'd3));
		push_req(make_req(OP_SET_CUR, 8'h00, 7'd0, 2'd0));
		push_req(make_req(OP_CUR_LEFT, 8'h00, 7'd0, 2'd0));
		push_req(make_req(OP_CUR_RIGHT, 8'h00, 7'd0, 2'd0));
		push_req(make_req(OP_SET_CUR, 8'h00, 7'd127, 2'd2));
		push_req(make_req(OP_DATA, 8'h41, 7'd0, 2'd0));
		push_req(make_req(OP_BLINK_ON, 8'h00, 7'd0, 2'd0));
		push_req(make_req(OP_BLINK_OFF, 8'hFF, 7'd127, 2'd3));
		push_req(make_req(OP_INIT, 8'hFF, 7'd127, 2'd3));

		for (phase = 0; phase < 4; phase++) begin
			hold_until_drained();
			send_idle_pct = send_pcts[phase];
			stall_pct     = stall_pcts[phase];
			case (phase)
				0: begin
					write_reg(CFG_ROW_ONE, 7'd0);
					write_reg(CFG_ROW_TWO, 7'd0);
					write_reg(CFG_ROW_THREE, 7'd0);
				end
				1: begin
					write_reg(CFG_ROW_ONE, 7'd127);
					write_reg(CFG_ROW_TWO, 7'd127);
					write_reg(CFG_ROW_THREE, 7'd127);
				end
				default: begin
					write_reg(CFG_ROW_ONE, 7'($urandom));
					write_reg(CFG_ROW_TWO, 7'($urandom));
					write_reg(CFG_ROW_THREE, 7'($urandom));
					// the spare index holds no register: must leave the offsets alone
					if (phase == 3)
						write_reg(CFG_SPARE, 7'($urandom));
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					hold_until_drained();
				push_req(random_req());
			end
		end

		hold_until_drained();
		if (errors == 0)
			$display("char_lcd_nibble_sequencer_core_tb: done, clean");
		else
			$display("char_lcd_nibble_sequencer_core_tb: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
sv/lcdns_pkg.sv
sv/lcdns_front.sv
sv/lcdns_queue.sv
sv/lcdns_back.sv
sv/char_lcd_nibble_sequencer_core.sv
bench/char_lcd_nibble_sequencer_core_checker.sv
bench/char_lcd_nibble_sequencer_core_tb.sv
